// ===== src/pstate_frequency_index_lookup_assert.svh =====
// Assertion macros shared by the P-state lookup RTL.
`ifndef PSTATE_FREQUENCY_INDEX_LOOKUP_ASSERT_SVH
`define PSTATE_FREQUENCY_INDEX_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
`define PFIL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PFIL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PFIL_ASSERT(lbl, clk, rst, prop, msg)
`define PFIL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/pfil_pkg.sv =====
// Shared constants, codes and types of the P-state lookup block.
package pfil_pkg;
   localparam int MAX_PSTATES = 32;
   localparam int IDX_W       = $clog2(MAX_PSTATES);
   localparam int KHZ_W       = 24;
   localparam int SLOT_W      = 5;
   localparam int PSTATE_W    = 5;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 6;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 6;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BOOST_ON    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_ZERO_QUERY = 2'd1,
      STAT_NO_MATCH   = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic step;
      logic capture;
   } dp_cmd_type;

   typedef struct packed {
      logic finish;
   } dp_status_type;
endpackage

// ===== src/pfil_req_if.sv =====
// Request channel: table loads and frequency lookups.
interface pfil_req_if;
   import pfil_pkg::*;
   logic                valid;
   logic                ready;
   logic                command;
   logic [SLOT_W-1:0]   entry_slot;
   logic [KHZ_W-1:0]    entry_khz;
   logic [KHZ_W-1:0]    query_khz;
   logic                nearest_mode;

   modport source (output valid, command, entry_slot, entry_khz, query_khz, nearest_mode,
                   input ready);
   modport sink (input valid, command, entry_slot, entry_khz, query_khz, nearest_mode,
                 output ready);
endinterface

// ===== src/pfil_rsp_if.sv =====
// Response channel: lookup results.
interface pfil_rsp_if;
   import pfil_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [PSTATE_W-1:0]   pstate_found;
   logic [KHZ_W-1:0]      found_khz;
   logic [STATUS_W-1:0]   status;

   modport source (output valid, pstate_found, found_khz, status, input ready);
   modport sink (input valid, pstate_found, found_khz, status, output ready);
endinterface

// ===== src/pstate_frequency_index_lookup.sv =====
// Top level of the P-state frequency index lookup block.
// The req_if channel carries two kinds of item. A load item (command 0) writes entry_khz into
// table slot entry_slot and gives no result. A lookup item
// (command 1) maps query_khz to a P-state index and gives one item on rsp_if with
// pstate_found, found_khz and status (0 ok, 1 zero query, 2 no exact match).
// The table is ordered from the highest frequency down and must be loaded before it is read.
// The csr_ port sets boost_on (index 0) and entry_count (index 1); write it only when idle.
// A lookup walks the table one entry per cycle from entry zero through a single registered
// memory read port, stopping at the first entry that decides the answer. The result is
// presented once the scan has read the deciding entry. No item is taken while a lookup
// scans; back in idle, loads can follow every cycle.
// The result sits in an output register, so the next item is accepted while it waits; a
// finished lookup holds until that register is free, and no load is taken while it holds.
// Synchronous reset sets boost_on to 0 and entry_count to 1 and drops any pending item; the
// table contents are kept.
module pstate_frequency_index_lookup (
   input  logic                              clock,
   input  logic                              reset,
   pfil_req_if.sink                          req_if,
   pfil_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [pfil_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pfil_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pfil_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;

   pfil_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_command (req_if.command),
      .req_ready   (req_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .cmd         (cmd),
      .sts         (sts)
   );

   pfil_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_entry_slot   (req_if.entry_slot),
      .req_entry_khz    (req_if.entry_khz),
      .req_query_khz    (req_if.query_khz),
      .req_nearest_mode (req_if.nearest_mode),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_pstate_found (rsp_if.pstate_found),
      .rsp_found_khz    (rsp_if.found_khz),
      .rsp_status       (rsp_if.status)
   );
endmodule

// ===== src/pfil_ctrl.sv =====
// Sequencer for the P-state lookup: accepts items, walks the table, holds the result.
module pfil_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_command,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pfil_pkg::dp_cmd_type    cmd,
   input  pfil_pkg::dp_status_type sts
);
   import pfil_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_LOOKUP) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // A finished lookup waits here while the previous result is still held.
            if (sts.finish) begin
               if (out_free) begin
                  cmd.capture  = 1'b1;
                  out_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`include "pstate_frequency_index_lookup_assert.svh"
   `PFIL_ASSERT_NEXT(a_lookup_enters_scan, clock, reset, state_ff == ST_IDLE && req_valid && req_command == CMD_LOOKUP, state_ff == ST_SCAN, "lookup did not start a scan")
   `PFIL_ASSERT_NEXT(a_scan_continues, clock, reset, state_ff == ST_SCAN && !sts.finish, state_ff == ST_SCAN, "scan left before finishing")
   `PFIL_ASSERT_NEXT(a_capture_presents, clock, reset, cmd.capture, rsp_valid && state_ff == ST_IDLE, "captured result not presented")
   `PFIL_ASSERT(a_cmd_exclusive, clock, reset, $onehot0({cmd.load, cmd.start, cmd.step, cmd.capture}), "datapath commands overlap")
endmodule

// ===== src/pfil_datapath.sv =====
// Datapath for the P-state lookup: frequency table, scan pointer, compares and result.
module pfil_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [pfil_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pfil_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [pfil_pkg::SLOT_W-1:0]        req_entry_slot,
   input  logic [pfil_pkg::KHZ_W-1:0]         req_entry_khz,
   input  logic [pfil_pkg::KHZ_W-1:0]         req_query_khz,
   input  logic                               req_nearest_mode,
   input  pfil_pkg::dp_cmd_type                cmd,
   output pfil_pkg::dp_status_type             sts,
   output logic [pfil_pkg::PSTATE_W-1:0]      rsp_pstate_found,
   output logic [pfil_pkg::KHZ_W-1:0]         rsp_found_khz,
   output logic [pfil_pkg::STATUS_W-1:0]      rsp_status
);
   import pfil_pkg::*;

   logic                 boost_ff;
   logic [COUNT_W-1:0]   entry_count_ff;
   logic [KHZ_W-1:0]     mem_ff [MAX_PSTATES];
   logic [KHZ_W-1:0]     rd_data_ff;
   logic [KHZ_W-1:0]     prev_ff;
   logic [IDX_W-1:0]     p_ff;
   logic [IDX_W-1:0]     last_ff, last_in;
   logic [KHZ_W-1:0]     query_ff;
   logic                 nearest_ff;
   logic [IDX_W-1:0]     res_idx_ff, res_idx_in;
   logic [KHZ_W-1:0]     res_khz_ff, res_khz_in;
   status_type           res_status_ff, res_status_in;

   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     nominal;
   logic [KHZ_W-1:0]     up_gap, down_gap;
   logic                 boost_slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         boost_ff       <= 1'b0;
         entry_count_ff <= COUNT_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_BOOST_ON:    boost_ff       <= csr_wdata[0];
            CSR_ENTRY_COUNT: entry_count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Index of the last entry in use, with the count clamped to the table.
   always_comb begin
      if (entry_count_ff == '0) begin
         last_in = '0;
      end else if (32'(entry_count_ff) > MAX_PSTATES) begin
         last_in = IDX_W'(MAX_PSTATES - 1);
      end else begin
         last_in = IDX_W'(entry_count_ff - 1'b1);
      end
   end

   assign rd_addr = cmd.start ? '0 : IDX_W'(p_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (cmd.load && (32'(req_entry_slot) < MAX_PSTATES)) begin
         mem_ff[IDX_W'(req_entry_slot)] <= req_entry_khz;
      end
      if (cmd.start || cmd.step) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         query_ff   <= req_query_khz;
         nearest_ff <= req_nearest_mode;
         last_ff    <= last_in;
         p_ff       <= '0;
      end else if (cmd.step) begin
         prev_ff <= rd_data_ff;
         p_ff    <= IDX_W'(p_ff + 1'b1);
      end
      if (cmd.capture) begin
         res_idx_ff    <= res_idx_in;
         res_khz_ff    <= res_khz_in;
         res_status_ff <= res_status_in;
      end
   end

   assign nominal    = IDX_W'(boost_ff);
   // With boost, entry zero is only checked for an exact match.
   assign boost_slot = boost_ff && (p_ff == '0);
   assign up_gap     = prev_ff - query_ff;
   assign down_gap   = query_ff - rd_data_ff;

   always_comb begin
      sts.finish    = 1'b1;
      res_idx_in    = p_ff;
      res_khz_in    = rd_data_ff;
      res_status_in = STAT_OK;
      if (query_ff == '0) begin
         res_idx_in    = '0;
         res_khz_in    = '0;
         res_status_in = STAT_ZERO_QUERY;
      end else if (query_ff == rd_data_ff) begin
         res_status_in = STAT_OK;
      end else if (nearest_ff && (query_ff > rd_data_ff) && !boost_slot) begin
         // The entry above wins only when strictly nearer; ties take the lower one.
         if ((p_ff > nominal) && (up_gap < down_gap)) begin
            res_idx_in = IDX_W'(p_ff - 1'b1);
            res_khz_in = prev_ff;
         end
      end else if (p_ff == last_ff) begin
         if (!nearest_ff) begin
            res_idx_in    = '0;
            res_khz_in    = '0;
            res_status_in = STAT_NO_MATCH;
         end
      end else begin
         sts.finish = 1'b0;
      end
   end

   assign rsp_pstate_found = PSTATE_W'(res_idx_ff);
   assign rsp_found_khz    = res_khz_ff;
   assign rsp_status       = res_status_ff;

`include "pstate_frequency_index_lookup_assert.svh"
   `PFIL_ASSERT_NEXT(a_step_advances, clock, reset, cmd.step, p_ff == IDX_W'($past(p_ff) + 1'b1), "scan pointer did not advance")
   `PFIL_ASSERT_NEXT(a_error_zeroes, clock, reset, cmd.capture, res_status_ff == STAT_OK || (res_idx_ff == '0 && res_khz_ff == '0), "error result carries data")
   `PFIL_ASSERT(a_step_in_range, clock, reset, cmd.step |-> p_ff < last_ff, "scan stepped past the last entry")
endmodule
